// ===== hw/rtl/gcbu_pkg.sv =====
// Shared types and constants of the column-block update datapath.
// Holds the register indexes, the binary64 special values and the normalizer hand-off type.
// No dependencies.
package gcbu_pkg;

    localparam int DW       = 64;
    localparam int WIDE_W   = 106;
    localparam int MUL_LAT  = 5;
    localparam int ADD_LAT  = 5;
    // The y value meets the scaled sum after two multiplies and two adds.
    localparam int ACC_DLY  = 2 * MUL_LAT + 2 * ADD_LAT;
    localparam int LAST_DLY = ACC_DLY + ADD_LAT;

    localparam logic [63:0] DEF_NAN   = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [63:0] ALPHA_RST = 64'h3FF0_0000_0000_0000;
    localparam logic [10:0] EXP_MAX   = 11'h7FF;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_MODE  = 3'd0;
    localparam cfg_idx_t REG_W0    = 3'd1;
    localparam cfg_idx_t REG_W1    = 3'd2;
    localparam cfg_idx_t REG_W2    = 3'd3;
    localparam cfg_idx_t REG_W3    = 3'd4;
    localparam cfg_idx_t REG_ALPHA = 3'd5;

    // Unrounded result: value is wide * 2^(etop - 1023 - 105) when the top bit sits at bit 105.
    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sign;
        logic signed [12:0] etop;
        logic [105:0]       wide;
    } gcbu_nrm_t;

    function automatic logic is_nan(input logic [63:0] x);
        is_nan = (x[62:52] == EXP_MAX) && (x[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        is_inf = (x[62:52] == EXP_MAX) && (x[51:0] == 52'd0);
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        is_zero = (x[62:0] == 63'd0);
    endfunction

endpackage

// ===== hw/rtl/gcbu_norm.sv =====
// Three-stage normalize, denormalize and round-to-nearest-even unit for binary64.
// Shared back end of the multiplier and the adder; uses gcbu_pkg.
module gcbu_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  gcbu_pkg::gcbu_nrm_t nin,
    output logic                out_valid,
    output logic [63:0]         res
);
    import gcbu_pkg::*;

    logic        v1_reg, v2_reg, v3_reg;
    gcbu_nrm_t   n1_reg;
    logic [6:0]  lz1_reg;
    logic [6:0]  lz_next;

    always_comb begin
        lz_next = 7'd106;
        for (int i = 0; i < WIDE_W; i++) begin
            if (nin.wide[i]) begin
                lz_next = 7'(WIDE_W - 1 - i);
            end
        end
    end

    // Stage 2: place the leading one, or shift it into the subnormal range.
    logic signed [13:0] em1, rn, lz_s;
    logic [13:0]        rs;
    logic [105:0]       sh;
    logic               rst_bit, ovf_next;
    logic [10:0]        ebits_next;

    always_comb begin
        em1        = $signed({n1_reg.etop[12], n1_reg.etop}) - 14'sd1;
        lz_s       = $signed({7'd0, lz1_reg});
        rn         = $signed({n1_reg.etop[12], n1_reg.etop}) - lz_s;
        rs         = 14'(-em1);
        sh         = '0;
        rst_bit    = 1'b0;
        ovf_next   = 1'b0;
        ebits_next = '0;
        if (em1 >= lz_s) begin
            sh         = n1_reg.wide << lz1_reg;
            ovf_next   = (rn >= 14'sd2047);
            ebits_next = 11'(rn - 14'sd1);
        end else if (!em1[13]) begin
            sh = n1_reg.wide << em1[6:0];
        end else if (rs >= 14'd106) begin
            rst_bit = |n1_reg.wide;
        end else begin
            sh      = n1_reg.wide >> rs[6:0];
            rst_bit = |(n1_reg.wide & ~({106{1'b1}} << rs[6:0]));
        end
    end

    logic        spec2_reg, sign2_reg, zero2_reg, ovf2_reg, g2_reg, st2_reg;
    logic [63:0] sval2_reg;
    logic [10:0] ebits2_reg;
    logic [52:0] mant2_reg;
    logic [63:0] res_next;
    logic        inc;

    always_comb begin
        inc = g2_reg & (st2_reg | mant2_reg[0]);
        if (spec2_reg) begin
            res_next = sval2_reg;
        end else if (zero2_reg) begin
            res_next = {sign2_reg, 63'd0};
        end else if (ovf2_reg) begin
            res_next = {sign2_reg, EXP_MAX, 52'd0};
        end else begin
            // A rounding carry walks into the exponent, up to infinity if it must.
            res_next = {sign2_reg, 63'({ebits2_reg, 52'd0}) + 63'(mant2_reg) + 63'(inc)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg     <= nin;
            lz1_reg    <= lz_next;
            spec2_reg  <= n1_reg.spec;
            sval2_reg  <= n1_reg.spec_val;
            sign2_reg  <= n1_reg.sign;
            zero2_reg  <= (n1_reg.wide == '0);
            ovf2_reg   <= ovf_next;
            ebits2_reg <= ebits_next;
            mant2_reg  <= sh[105:53];
            g2_reg     <= sh[52];
            st2_reg    <= (|sh[51:0]) | rst_bit;
            res        <= res_next;
        end
    end

    assign out_valid = v3_reg;

endmodule

// ===== hw/rtl/gcbu_fmul.sv =====
// Five-stage binary64 multiplier: partial products, product sum, then the shared rounder.
// Uses gcbu_pkg and gcbu_norm.
module gcbu_fmul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        out_valid,
    output logic [63:0] res
);
    import gcbu_pkg::*;

    logic [52:0] ma, mb;
    logic [10:0] ea, eb;
    logic        sgn;
    logic        spec_next;
    logic [63:0] sval_next;

    always_comb begin
        ea  = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
        eb  = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
        ma  = {a[62:52] != 11'd0, a[51:0]};
        mb  = {b[62:52] != 11'd0, b[51:0]};
        sgn = a[63] ^ b[63];
        spec_next = 1'b1;
        if (is_nan(a)) begin
            sval_next = a | QUIET_BIT;
        end else if (is_nan(b)) begin
            sval_next = b | QUIET_BIT;
        end else if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) begin
            sval_next = DEF_NAN;
        end else if (is_inf(a) || is_inf(b)) begin
            sval_next = {sgn, EXP_MAX, 52'd0};
        end else begin
            spec_next = 1'b0;
            sval_next = '0;
        end
    end

    logic               v1_reg, v2_reg;
    logic [51:0]        hh_reg;
    logic [52:0]        hl_reg, lh_reg;
    logic [53:0]        ll_reg;
    logic               sign1_reg, spec1_reg;
    logic [63:0]        sval1_reg;
    logic signed [12:0] etop1_reg;
    gcbu_nrm_t          n2_reg, n2_next;

    always_comb begin
        n2_next.spec     = spec1_reg;
        n2_next.spec_val = sval1_reg;
        n2_next.sign     = sign1_reg;
        n2_next.etop     = etop1_reg;
        n2_next.wide     = ({54'd0, hh_reg} << 54) + ({53'd0, hl_reg} << 27)
                         + ({53'd0, lh_reg} << 27) + {52'd0, ll_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg    <= ma[52:27] * mb[52:27];
            hl_reg    <= ma[52:27] * mb[26:0];
            lh_reg    <= ma[26:0] * mb[52:27];
            ll_reg    <= ma[26:0] * mb[26:0];
            sign1_reg <= sgn;
            spec1_reg <= spec_next;
            sval1_reg <= sval_next;
            etop1_reg <= $signed({2'b00, ea}) + $signed({2'b00, eb}) - 13'sd1022;
            n2_reg    <= n2_next;
        end
    end

    gcbu_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .nin       (n2_reg),
        .out_valid (out_valid),
        .res       (res)
    );

endmodule

// ===== hw/rtl/gcbu_fadd.sv =====
// Five-stage binary64 adder: order by magnitude, align and add, then the shared rounder.
// Uses gcbu_pkg and gcbu_norm.
module gcbu_fadd (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        out_valid,
    output logic [63:0] res
);
    import gcbu_pkg::*;

    logic        spec_next;
    logic [63:0] sval_next;
    logic        a_big;

    always_comb begin
        a_big     = (a[62:0] >= b[62:0]);
        spec_next = 1'b1;
        if (is_nan(a)) begin
            sval_next = a | QUIET_BIT;
        end else if (is_nan(b)) begin
            sval_next = b | QUIET_BIT;
        end else if (is_inf(a) && is_inf(b) && (a[63] != b[63])) begin
            sval_next = DEF_NAN;
        end else if (is_inf(a)) begin
            sval_next = a;
        end else if (is_inf(b)) begin
            sval_next = b;
        end else begin
            spec_next = 1'b0;
            sval_next = '0;
        end
    end

    logic        v1_reg, v2_reg;
    logic [63:0] big_reg, sml_reg, sval1_reg;
    logic        spec1_reg, zsign1_reg;
    gcbu_nrm_t   n2_reg, n2_next;

    // Stage 2: shift the smaller operand, jam what falls off into the lowest bit, then add or subtract it.
    logic [10:0]  e_big, e_sml, d;
    logic [104:0] a_al, b_al, b_sh, b_jam;
    logic         lost;
    logic [105:0] sum;

    always_comb begin
        e_big = (big_reg[62:52] == 11'd0) ? 11'd1 : big_reg[62:52];
        e_sml = (sml_reg[62:52] == 11'd0) ? 11'd1 : sml_reg[62:52];
        d     = e_big - e_sml;
        a_al  = {big_reg[62:52] != 11'd0, big_reg[51:0], 52'd0};
        b_al  = {sml_reg[62:52] != 11'd0, sml_reg[51:0], 52'd0};
        if (d >= 11'd105) begin
            b_sh = '0;
            lost = |b_al;
        end else begin
            b_sh = b_al >> d[6:0];
            lost = |(b_al & ~({105{1'b1}} << d[6:0]));
        end
        b_jam = b_sh | {104'd0, lost};
        if (big_reg[63] != sml_reg[63]) begin
            sum = {1'b0, a_al} - {1'b0, b_jam};
        end else begin
            sum = {1'b0, a_al} + {1'b0, b_jam};
        end
        n2_next.spec     = spec1_reg;
        n2_next.spec_val = sval1_reg;
        // An exact zero is negative only when both operands were negative.
        n2_next.sign     = (sum == '0) ? zsign1_reg : big_reg[63];
        n2_next.etop     = $signed({2'b00, e_big}) + 13'sd1;
        n2_next.wide     = sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            big_reg    <= a_big ? a : b;
            sml_reg    <= a_big ? b : a;
            spec1_reg  <= spec_next;
            sval1_reg  <= sval_next;
            zsign1_reg <= a[63] & b[63];
            n2_reg     <= n2_next;
        end
    end

    gcbu_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .nin       (n2_reg),
        .out_valid (out_valid),
        .res       (res)
    );

endmodule

// ===== hw/rtl/gemv_column_block_update.sv =====
// One row of y += alpha * (A * x) over a block of four (or two) columns in binary64.
// A fully pipelined datapath of four multipliers, three adders, the alpha multiplier
// and the final adder takes one item per clock while its output item is taken.
// The depth is set by the chain multiply, add, add, multiply, add of five stages each.
// When a valid output item waits, the whole pipeline holds, and s_tready follows
// m_tready then. Configuration registers must be written while no item is in flight.
// Depends on gcbu_pkg, gcbu_fmul and gcbu_fadd.
module gemv_column_block_update (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // elem_col_zero, elem_col_one, elem_col_two, elem_col_three, acc_in
    input  logic [319:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // acc_out
    output logic [63:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  gcbu_pkg::cfg_idx_t cfg_addr,
    input  logic [63:0]  cfg_wdata
);
    import gcbu_pkg::*;

    logic        mode_reg;
    logic [63:0] w0_reg, w1_reg, w2_reg, w3_reg, alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b1;
            w0_reg    <= '0;
            w1_reg    <= '0;
            w2_reg    <= '0;
            w3_reg    <= '0;
            alpha_reg <= ALPHA_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MODE:  mode_reg  <= cfg_wdata[0];
                REG_W0:    w0_reg    <= cfg_wdata;
                REG_W1:    w1_reg    <= cfg_wdata;
                REG_W2:    w2_reg    <= cfg_wdata;
                REG_W3:    w3_reg    <= cfg_wdata;
                REG_ALPHA: alpha_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en, accept;
    assign en       = m_tready | ~m_tvalid;
    assign s_tready = en;
    assign accept   = s_tvalid & en;

    logic [63:0] p0, p1, p2, p3, s01, s23, sum_ab, scaled;
    logic        p0_v, s01_v, sum_v, scaled_v;
    logic [63:0] sum_b;

    gcbu_fmul u_mul0 (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(accept),
                      .a(s_tdata[63:0]), .b(w0_reg), .out_valid(p0_v), .res(p0));
    gcbu_fmul u_mul1 (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(accept),
                      .a(s_tdata[127:64]), .b(w1_reg), .out_valid(), .res(p1));
    gcbu_fmul u_mul2 (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(accept),
                      .a(s_tdata[191:128]), .b(w2_reg), .out_valid(), .res(p2));
    gcbu_fmul u_mul3 (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(accept),
                      .a(s_tdata[255:192]), .b(w3_reg), .out_valid(), .res(p3));

    gcbu_fadd u_add01 (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p0_v),
                       .a(p0), .b(p1), .out_valid(s01_v), .res(s01));
    gcbu_fadd u_add23 (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(p0_v),
                       .a(p2), .b(p3), .out_valid(), .res(s23));

    // In two-column mode adding negative zero passes the left sum through unchanged.
    assign sum_b = mode_reg ? s23 : NEG_ZERO;

    gcbu_fadd u_addsum (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s01_v),
                        .a(s01), .b(sum_b), .out_valid(sum_v), .res(sum_ab));
    gcbu_fmul u_mulal (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(sum_v),
                       .a(sum_ab), .b(alpha_reg), .out_valid(scaled_v), .res(scaled));

    logic [63:0] acc_dly_reg [ACC_DLY];
    logic        last_dly_reg [LAST_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_dly_reg[0]  <= s_tdata[319:256];
            last_dly_reg[0] <= s_tlast;
            for (int i = 1; i < ACC_DLY; i++) begin
                acc_dly_reg[i] <= acc_dly_reg[i-1];
            end
            for (int i = 1; i < LAST_DLY; i++) begin
                last_dly_reg[i] <= last_dly_reg[i-1];
            end
        end
    end

    gcbu_fadd u_addy (.aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(scaled_v),
                      .a(acc_dly_reg[ACC_DLY-1]), .b(scaled), .out_valid(m_tvalid),
                      .res(m_tdata));

    assign m_tlast = last_dly_reg[LAST_DLY-1];

endmodule

// ===== hw/rtl/gcbu_chk.sv =====
// Port-level checks of the column-block update pipeline and their binding.
// Sees only the top level's ports; depends on nothing else.
module gcbu_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    a_rst_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output item valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed or vanished");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input item taken while the pipeline is stalled");

    a_no_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input refused although the output stage is empty");

endmodule

bind gemv_column_block_update gcbu_chk u_gcbu_chk (.*);
